/* hw/rtl/fiber_conductivity_tensor_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the conductivity tensor block
// Clocked implication shorthands with reset disable.
// ----------------------------------------------------------------------------
`ifndef FIBER_CONDUCTIVITY_TENSOR_ASSERT_SVH
`define FIBER_CONDUCTIVITY_TENSOR_ASSERT_SVH

// same-cycle implication
`define FCT_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FCT_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/fct_pkg.sv */
// ----------------------------------------------------------------------------
// Conductivity tensor package
// Shared widths, types, register codes and rounding helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package fct_pkg;

	localparam int CODE_W = 8;
	localparam int CODES  = 1 << CODE_W;
	localparam int TRIG_W = 18;   // signed Q1.16, magnitude up to 1.0
	localparam int Q31_W  = 33;   // signed Q31, magnitude up to 1.0
	localparam int ACC_W  = 34;   // sum of two Q31 squares
	localparam int RND_W  = 96;   // working width for rounding

	localparam longint unsigned PI_Q30  = 64'd3373259426;
	localparam longint unsigned ONE_Q30 = 64'd1073741824;

	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t REG_SIGMA_LONG  = 1'b0;
	localparam cfg_idx_t REG_SIGMA_TRANS = 1'b1;

	typedef logic signed [TRIG_W-1:0] trig_t;
	typedef logic signed [Q31_W-1:0]  q31_t;
	typedef logic signed [ACC_W-1:0]  acc_t;
	typedef logic signed [RND_W-1:0]  rnd_t;
	typedef trig_t trig_tab_t [CODES];

	// shift right by sh, round to nearest with ties away from zero
	function automatic rnd_t round_away(input rnd_t v, input int unsigned sh);
		rnd_t mag;
		rnd_t r;
		mag = v[RND_W-1] ? -v : v;
		r   = (mag + (rnd_t'(1) <<< (sh - 1))) >>> sh;
		return v[RND_W-1] ? -r : r;
	endfunction

	// product of two Q1.16 values scaled to Q31, rounded back to Q31
	function automatic q31_t mul_trig(input trig_t a, input trig_t b);
		rnd_t p;
		p = a * b;
		return q31_t'(round_away(p, 1));
	endfunction

	// product of two Q31 values, rounded back to Q31
	function automatic q31_t mul_q31(input q31_t a, input q31_t b);
		rnd_t p;
		p = a * b;
		return q31_t'(round_away(p, 31));
	endfunction

	// product of a Q31 value and a Q1.16 value scaled to Q31
	function automatic q31_t mul_q31_trig(input q31_t a, input trig_t b);
		rnd_t p;
		p = a * b;
		return q31_t'(round_away(p, 16));
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/fct_if.sv */
// ----------------------------------------------------------------------------
// Conductivity tensor channels
// Valid/ready channels for angle items and tensor items.
// ----------------------------------------------------------------------------
`default_nettype none

interface fct_angle_if;
	import fct_pkg::*;
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] phi_code;
	logic [CODE_W-1:0] theta_code;

	modport source (output valid, output phi_code, output theta_code, input ready);
	modport sink (input valid, input phi_code, input theta_code, output ready);
endinterface

interface fct_tensor_if #(
	parameter int OUT_W = 25
);
	logic                    valid;
	logic                    ready;
	logic [OUT_W-1:0]        t_xx;
	logic [OUT_W-1:0]        t_yy;
	logic [OUT_W-1:0]        t_zz;
	logic signed [OUT_W-1:0] t_xy;
	logic signed [OUT_W-1:0] t_xz;
	logic signed [OUT_W-1:0] t_yz;
	logic                    xx_not_positive;

	modport source (
		output valid, output t_xx, output t_yy, output t_zz,
		output t_xy, output t_xz, output t_yz, output xx_not_positive,
		input ready
	);
	modport sink (
		input valid, input t_xx, input t_yy, input t_zz,
		input t_xy, input t_xz, input t_yz, input xx_not_positive,
		output ready
	);
endinterface

`default_nettype wire

/* hw/rtl/fiber_conductivity_tensor.sv */
// ----------------------------------------------------------------------------
// Fibre conductivity tensor: rotated anisotropic tensor from two angle codes
// Accepts one item per cycle while the output stage is empty or tensor.ready is high.
// Seven register stages: lookup, two rounded multiply levels, sum, scale, add, round.
// arst_n clears the valid bits and both conductivities; trig tables are constant.
// ----------------------------------------------------------------------------
`default_nettype none

module fiber_conductivity_tensor #(
	parameter int ANGLE_STEPS = 256,
	parameter int FRAC_BITS   = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  fct_pkg::cfg_idx_t    cfg_idx,
	input  logic [FRAC_BITS+3:0] cfg_wdata,
	fct_angle_if.sink            angles,
	fct_tensor_if.source         tensor
);
	import fct_pkg::*;

	// Conductivities are Q4.F, results Q5.F; the fraction cancels in the maths.
	localparam int SIG_W  = FRAC_BITS + 4;
	localparam int OUT_W  = SIG_W + 1;
	localparam int DIF_W  = SIG_W + 1;
	localparam int PROD_W = DIF_W + ACC_W;
	localparam int SUM_W  = PROD_W + 1;

	localparam rnd_t DIAG_MAX = (rnd_t'(1) <<< OUT_W) - rnd_t'(1);
	localparam rnd_t OFF_MAX  = (rnd_t'(1) <<< (OUT_W - 1)) - rnd_t'(1);
	localparam rnd_t OFF_MIN  = -OFF_MAX;

	// Angle period is pi/ANGLE_STEPS per code; cosine runs at half step.
	localparam longint unsigned SIN_DEN = longint'(ANGLE_STEPS);
	localparam longint unsigned COS_DEN = 2 * SIN_DEN;
	localparam longint unsigned SIN_RND = SIN_DEN / 2;
	localparam longint unsigned COS_RND = COS_DEN / 2;
	localparam longint unsigned SIN_PER = 2 * SIN_DEN;
	localparam longint unsigned COS_PER = 2 * COS_DEN;

	// ------------------------------------------------------------------
	// Elaboration-time trig tables.
	// sin(num*pi/den), den chosen by cos_sel, as signed Q1.16 via a Taylor
	// series through x^17 in Q30, clamped to [0,1] before rounding.
	// ------------------------------------------------------------------
	function automatic trig_t trig_q16(input longint unsigned num, input bit cos_sel);
		longint unsigned den;
		longint unsigned m;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned q16;
		longint          sum;
		bit              neg;
		den = cos_sel ? COS_DEN : SIN_DEN;
		m   = cos_sel ? (num % COS_PER) : (num % SIN_PER);
		neg = 1'b0;
		if (m >= den) begin
			neg = 1'b1;
			m   = m - den;
		end
		if (2 * m > den)
			m = den - m;
		x = cos_sel ? (m * PI_Q30 + COS_RND) / COS_DEN : (m * PI_Q30 + SIN_RND) / SIN_DEN;
		x2   = (x * x) >> 30;
		sum  = longint'(x);
		term = x;
		term = ((term * x2) >> 30) / 6;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 20;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 42;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 72;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 110;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 156;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 210;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 272;
		sum  = sum + longint'(term);
		if (sum < 0)
			sum = 0;
		if (sum > longint'(ONE_Q30))
			sum = longint'(ONE_Q30);
		q16 = (longint'(sum) + 64'd8192) >> 14;
		return neg ? -trig_t'(q16) : trig_t'(q16);
	endfunction

	function automatic trig_tab_t build_tab(input bit cos_sel);
		trig_tab_t       tab;
		longint unsigned num;
		for (int c = 0; c < CODES; c++) begin
			num = longint'(c);
			if (cos_sel)
				num = 2 * num + SIN_DEN;
			tab[c] = trig_q16(num, cos_sel);
		end
		return tab;
	endfunction

	localparam trig_tab_t SIN_TAB = build_tab(1'b0);
	localparam trig_tab_t COS_TAB = build_tab(1'b1);

	// Saturate a rounded diagonal entry to [0, 2^OUT_W - 1]
	function automatic logic [OUT_W-1:0] clamp_diag(input rnd_t v);
		if (v[RND_W-1])
			return '0;
		else if (v > DIAG_MAX)
			return DIAG_MAX[OUT_W-1:0];
		return v[OUT_W-1:0];
	endfunction

	// Saturate a rounded off-diagonal entry to +/-(2^(OUT_W-1) - 1)
	function automatic logic signed [OUT_W-1:0] clamp_off(input rnd_t v);
		if (v > OFF_MAX)
			return OFF_MAX[OUT_W-1:0];
		else if (v < OFF_MIN)
			return OFF_MIN[OUT_W-1:0];
		return v[OUT_W-1:0];
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [SIG_W-1:0] sigma_long_q;
	logic [SIG_W-1:0] sigma_trans_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_long_q  <= '0;
			sigma_trans_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SIGMA_LONG:  sigma_long_q  <= cfg_wdata;
				REG_SIGMA_TRANS: sigma_trans_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Conductivities as signed operands; the user must change the registers only while idle (not enforced here).
	logic signed [DIF_W-1:0] sl_x;
	logic signed [DIF_W-1:0] st_x;
	logic signed [DIF_W-1:0] d_x;

	assign sl_x = $signed({1'b0, sigma_long_q});
	assign st_x = $signed({1'b0, sigma_trans_q});
	assign d_x  = sl_x - st_x;

	// ------------------------------------------------------------------
	// Pipeline control: one global advance. The whole pipe holds while a
	// finished item waits in the output stage; otherwise every stage moves.
	// ------------------------------------------------------------------
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	assign adv          = !v_s7 || tensor.ready;
	assign angles.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= angles.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// ------------------------------------------------------------------
	// Datapath registers
	// ------------------------------------------------------------------
	// S1: table lookups
	trig_t sp_s1, cp_s1, st_s1, ct_s1;
	// S2: squares and trig cross products in Q31
	q31_t  sp2_s2, cp2_s2, st2_s2, ct2_s2, cpsp_s2, ctcp_s2, spct_s2;
	trig_t st_s2;
	// S3: second-level products
	q31_t  cs_s3, cc_s3, ss_s3, sc_s3, sp2_s3, cp2_s3, st2_s3, ct2_s3;
	q31_t  xyf_s3, xzf_s3, yzf_s3;
	// S4: diagonal sums of transverse factors
	acc_t  axx_s4, ayy_s4;
	q31_t  cs_s4, ss_s4, st2_s4, ct2_s4, xyf_s4, xzf_s4, yzf_s4;
	// S5: scaling by conductivities
	logic signed [PROD_W-1:0] pxl_s5, pxt_s5, pyl_s5, pyt_s5, pzl_s5, pzt_s5;
	logic signed [PROD_W-1:0] pxy_s5, pxz_s5, pyz_s5;
	// S6: diagonal sums
	logic signed [SUM_W-1:0]  sxx_s6, syy_s6, szz_s6;
	logic signed [PROD_W-1:0] pxy_s6, pxz_s6, pyz_s6;
	// S7: output register
	logic [OUT_W-1:0]         t_xx_s7, t_yy_s7, t_zz_s7;
	logic signed [OUT_W-1:0]  t_xy_s7, t_xz_s7, t_yz_s7;
	logic                     flag_s7;

	// Final rounding to Q.F and saturation
	rnd_t xx_r, yy_r, zz_r;

	always_comb begin
		xx_r = round_away(rnd_t'(sxx_s6), 31);
		yy_r = round_away(rnd_t'(syy_s6), 31);
		zz_r = round_away(rnd_t'(szz_s6), 31);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// S1: look up sine and cosine of both angles
			sp_s1 <= SIN_TAB[angles.phi_code];
			cp_s1 <= COS_TAB[angles.phi_code];
			st_s1 <= SIN_TAB[angles.theta_code];
			ct_s1 <= COS_TAB[angles.theta_code];

			// S2: first products
			sp2_s2  <= mul_trig(sp_s1, sp_s1);
			cp2_s2  <= mul_trig(cp_s1, cp_s1);
			st2_s2  <= mul_trig(st_s1, st_s1);
			ct2_s2  <= mul_trig(ct_s1, ct_s1);
			cpsp_s2 <= mul_trig(cp_s1, sp_s1);
			ctcp_s2 <= mul_trig(ct_s1, cp_s1);
			spct_s2 <= mul_trig(sp_s1, ct_s1);
			st_s2   <= st_s1;

			// S3: second products
			cs_s3  <= mul_q31(cp2_s2, st2_s2);
			cc_s3  <= mul_q31(cp2_s2, ct2_s2);
			ss_s3  <= mul_q31(sp2_s2, st2_s2);
			sc_s3  <= mul_q31(sp2_s2, ct2_s2);
			xyf_s3 <= mul_q31(cpsp_s2, st2_s2);
			xzf_s3 <= mul_q31_trig(ctcp_s2, st_s2);
			yzf_s3 <= mul_q31_trig(spct_s2, st_s2);
			sp2_s3 <= sp2_s2;
			cp2_s3 <= cp2_s2;
			st2_s3 <= st2_s2;
			ct2_s3 <= ct2_s2;

			// S4: transverse factors of xx and yy
			axx_s4 <= acc_t'(cc_s3) + acc_t'(sp2_s3);
			ayy_s4 <= acc_t'(cp2_s3) + acc_t'(sc_s3);
			cs_s4  <= cs_s3;
			ss_s4  <= ss_s3;
			st2_s4 <= st2_s3;
			ct2_s4 <= ct2_s3;
			xyf_s4 <= xyf_s3;
			xzf_s4 <= xzf_s3;
			yzf_s4 <= yzf_s3;

			// S5: scale by conductivities
			pxl_s5 <= sl_x * cs_s4;
			pxt_s5 <= st_x * axx_s4;
			pyl_s5 <= sl_x * ss_s4;
			pyt_s5 <= st_x * ayy_s4;
			pzl_s5 <= sl_x * ct2_s4;
			pzt_s5 <= st_x * st2_s4;
			pxy_s5 <= d_x * xyf_s4;
			pxz_s5 <= d_x * xzf_s4;
			pyz_s5 <= d_x * yzf_s4;

			// S6: add longitudinal and transverse parts
			sxx_s6 <= SUM_W'(pxl_s5) + SUM_W'(pxt_s5);
			syy_s6 <= SUM_W'(pyl_s5) + SUM_W'(pyt_s5);
			szz_s6 <= SUM_W'(pzl_s5) + SUM_W'(pzt_s5);
			pxy_s6 <= pxy_s5;
			pxz_s6 <= pxz_s5;
			pyz_s6 <= pyz_s5;

			// S7: round, saturate, flag a non-positive xx
			t_xx_s7 <= clamp_diag(xx_r);
			t_yy_s7 <= clamp_diag(yy_r);
			t_zz_s7 <= clamp_diag(zz_r);
			t_xy_s7 <= clamp_off(round_away(rnd_t'(pxy_s6), 31));
			t_xz_s7 <= clamp_off(round_away(rnd_t'(pxz_s6), 31));
			t_yz_s7 <= clamp_off(round_away(rnd_t'(pyz_s6), 31));
			flag_s7 <= xx_r[RND_W-1] || (xx_r == '0);
		end
	end

	// Drive the output item from the last stage
	assign tensor.valid           = v_s7;
	assign tensor.t_xx            = t_xx_s7;
	assign tensor.t_yy            = t_yy_s7;
	assign tensor.t_zz            = t_zz_s7;
	assign tensor.t_xy            = t_xy_s7;
	assign tensor.t_xz            = t_xz_s7;
	assign tensor.t_yz            = t_yz_s7;
	assign tensor.xx_not_positive = flag_s7;

endmodule

`default_nettype wire

/* hw/rtl/fct_checker.sv */
// ----------------------------------------------------------------------------
// Conductivity tensor port checker
// Watches the channel ports of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fiber_conductivity_tensor_assert.svh"

module fct_checker #(
	parameter int OUT_W = 25
) (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [OUT_W-1:0] t_xx,
	input logic             xx_not_positive
);

	// hold a refused item unchanged
	`FCT_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(t_xx), "tensor item changed while stalled")

	// empty output stage never refuses an item
	`FCT_ASSERT_IMP(a_in_free, clk, arst_n, !out_valid, in_ready, "input refused with empty output stage")

	// a stalled output holds the whole pipe
	`FCT_ASSERT_IMP(a_in_stall, clk, arst_n, out_valid && !out_ready, !in_ready, "input accepted while output stalled")

	// flag follows the saturated xx entry
	`FCT_ASSERT_IMP(a_flag_xx, clk, arst_n, out_valid && in_valid, xx_not_positive == (t_xx == '0), "xx flag disagrees with t_xx")

endmodule

bind fiber_conductivity_tensor fct_checker #(
	.OUT_W(FRAC_BITS + 5)
) u_fct_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (angles.valid),
	.in_ready        (angles.ready),
	.out_valid       (tensor.valid),
	.out_ready       (tensor.ready),
	.t_xx            (tensor.t_xx),
	.xx_not_positive (tensor.xx_not_positive)
);

`default_nettype wire
